/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_CLK(lbl, clk, rst, !(cond))

`endif

/* sv/cvc_pkg.sv */
// ----------------------------------------------------------------------------
// cvc_pkg
// types, constants and helpers of the collision velocity clipper
// ----------------------------------------------------------------------------
package cvc_pkg;

  localparam int RECT_SLOTS_DEF   = 16;
  localparam int CIRCLE_SLOTS_DEF = 16;
  localparam int MAX_SLOTS        = 256;

  // op codes of an input word
  localparam logic [1:0] OP_RECT   = 2'd0;
  localparam logic [1:0] OP_CIRCLE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_COUNT = 1'b1;

  localparam logic signed [35:0] ONE_Q16 = 36'sd65536;

  // shared unit step counts
  localparam int ALU_CNT_W  = 7;
  localparam int MUL_STEPS  = 33;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
    logic signed [31:0] other_x;
    logic signed [31:0] other_z;
    logic signed [31:0] speed_y;
    logic [30:0]        radius;
    logic               hold_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] clipped_x;
    logic signed [31:0] clipped_y;
    logic signed [31:0] clipped_z;
    logic               x_blocked;
    logic               z_blocked;
  } result_t;

  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] hi_x;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_z;
  } rect_t;

  typedef struct packed {
    logic               keep_in;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_z;
    logic signed [31:0] rad;
  } circ_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic        go;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RECT_RD,
    S_RECT_TEST,
    S_CIRC_PREP,
    S_CIRC_RD,
    S_CIRC_DIFF,
    S_SQX_GO,
    S_SQX_WAIT,
    S_SQZ_GO,
    S_SQZ_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DECIDE,
    S_MULX_GO,
    S_MULX_WAIT,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_MULZ_GO,
    S_MULZ_WAIT,
    S_DIVZ_GO,
    S_DIVZ_WAIT,
    S_CIRC_NEXT,
    S_FINISH
  } seq_state_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // point inside a padded rectangle, edges inclusive
  function automatic logic holds(input rect_t r, input logic signed [32:0] x,
                                 input logic signed [32:0] z);
    return (x >= 33'(r.lo_x)) && (x <= 33'(r.hi_x)) &&
           (z >= 33'(r.lo_z)) && (z <= 33'(r.hi_z));
  endfunction

endpackage

/* sv/cvc_ram.sv */
// ----------------------------------------------------------------------------
// cvc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module cvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/cvc_alu.sv */
// ----------------------------------------------------------------------------
// cvc_alu
// bit-serial multiply, restoring divide and integer square root
// ----------------------------------------------------------------------------
module cvc_alu (
  input  logic              clk,
  input  logic              rst,
  input  cvc_pkg::alu_req_t req,
  output cvc_pkg::alu_rsp_t rsp
);

  cvc_pkg::alu_op_t             op;
  logic [63:0]                  x;
  logic [63:0]                  y;
  logic [63:0]                  z;
  logic [cvc_pkg::ALU_CNT_W-1:0] cnt;
  logic                         done;

  logic [64:0] rem_sh;
  logic        rem_ge;
  logic [63:0] root_t;

  // per-step arithmetic
  always_comb begin
    rem_sh = {z, x[63]};
    rem_ge = rem_sh >= {1'b0, y};
    root_t = y + z;
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.go) begin
      done <= 1'b0;
      case (req.op)
        cvc_pkg::ALU_MUL:  cnt <= cvc_pkg::ALU_CNT_W'(cvc_pkg::MUL_STEPS);
        cvc_pkg::ALU_DIV:  cnt <= cvc_pkg::ALU_CNT_W'(cvc_pkg::DIV_STEPS);
        default:           cnt <= cvc_pkg::ALU_CNT_W'(cvc_pkg::SQRT_STEPS);
      endcase
    end else begin
      done <= (cnt == cvc_pkg::ALU_CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      op <= req.op;
      unique case (req.op)
        cvc_pkg::ALU_MUL: begin
          x <= req.a;
          y <= req.b;
          z <= '0;
        end
        cvc_pkg::ALU_DIV: begin
          x <= req.a;
          y <= req.b;
          z <= '0;
        end
        default: begin
          x <= req.a;
          y <= '0;
          z <= 64'h4000_0000_0000_0000;
        end
      endcase
    end else if (cnt != '0) begin
      unique case (op)
        cvc_pkg::ALU_MUL: begin
          if (y[0]) begin
            z <= z + x;
          end
          x <= {x[62:0], 1'b0};
          y <= {1'b0, y[63:1]};
        end
        cvc_pkg::ALU_DIV: begin
          z <= rem_ge ? 64'(rem_sh - {1'b0, y}) : 64'(rem_sh);
          x <= {x[62:0], rem_ge};
        end
        default: begin
          if (x >= root_t) begin
            x <= x - root_t;
            y <= {1'b0, y[63:1]} + z;
          end else begin
            y <= {1'b0, y[63:1]};
          end
          z <= {2'b00, z[63:2]};
        end
      endcase
    end
  end

  // result select
  always_comb begin
    rsp.done = done;
    unique case (op)
      cvc_pkg::ALU_MUL: rsp.result = z;
      cvc_pkg::ALU_DIV: rsp.result = x;
      default:          rsp.result = y;
    endcase
  end

endmodule

/* sv/collision_velocity_clip.sv */
// ----------------------------------------------------------------------------
// collision_velocity_clip
// clips a velocity against rectangle and circle colliders in the x/z plane
// ----------------------------------------------------------------------------
// channel   ports                               handshake
// input     start, busy, item                   taken when start & !busy
// config    cfg_we, cfg_index, cfg_data         taken when cfg_we
// result    done, result                        one-cycle strobe on done
//
// a slot write never raises busy
// a query holds busy while it walks the nr rectangles and nc circles, longer for
// each circle that pushes; the next word can be taken the cycle after done
// the bit-serial multiply, divide and root unit sets the length of a query
// rst clears the counts and the sequencer; table slots hold garbage until written
// results cannot be stalled: done is high for exactly one cycle
// ----------------------------------------------------------------------------
module collision_velocity_clip #(
  parameter int RECT_SLOTS   = cvc_pkg::RECT_SLOTS_DEF,
  parameter int CIRCLE_SLOTS = cvc_pkg::CIRCLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  cvc_pkg::item_t                 item,
  input  logic                           cfg_we,
  input  logic [cvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output cvc_pkg::result_t               result
);

  localparam int RAW   = (RECT_SLOTS > 1) ? $clog2(RECT_SLOTS) : 1;
  localparam int CAW   = (CIRCLE_SLOTS > 1) ? $clog2(CIRCLE_SLOTS) : 1;
  localparam int SLOTS = (RECT_SLOTS > CIRCLE_SLOTS) ? RECT_SLOTS : CIRCLE_SLOTS;
  localparam int IDX_W = $clog2(SLOTS + 1);

  cvc_pkg::seq_state_t state, state_next;

  logic [cvc_pkg::CFG_DATA_W-1:0] rect_count;
  logic [cvc_pkg::CFG_DATA_W-1:0] circle_count;
  logic [IDX_W-1:0]               nr, nc, idx;

  logic accept;
  logic rect_we, circ_we;
  cvc_pkg::rect_t rect_wdata, rect_rd;
  cvc_pkg::circ_t circ_wdata, circ_rd;

  cvc_pkg::alu_req_t alu_req;
  cvc_pkg::alu_rsp_t alu_rsp;

  // query datapath registers
  logic signed [31:0] cx, cz, ox, oz, vy;
  logic signed [32:0] mx, mz;
  logic signed [31:0] nx, ny, nz;
  logic               xb, zb;
  logic signed [31:0] dx, dz, rad;
  logic               keep;
  logic [63:0]        acc;
  logic [31:0]        radial;
  logic signed [33:0] gap;

  logic               idx_last;
  logic [31:0]        adx, adz;
  logic [32:0]        agap;
  logic               act;
  logic signed [35:0] push;

  assign accept = start && !busy;

  // clamp the counts to the table sizes
  always_comb begin
    nr = (32'(rect_count) < RECT_SLOTS) ? IDX_W'(rect_count) : IDX_W'(RECT_SLOTS);
    nc = (32'(circle_count) < CIRCLE_SLOTS) ? IDX_W'(circle_count)
                                           : IDX_W'(CIRCLE_SLOTS);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count   <= '0;
      circle_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cvc_pkg::CFG_RECT_COUNT:   rect_count   <= cfg_data;
        cvc_pkg::CFG_CIRCLE_COUNT: circle_count <= cfg_data;
      endcase
    end
  end

  // padded slot contents of a write word
  always_comb begin
    logic signed [31:0] min_x, max_x, min_z, max_z;
    min_x = (item.coord_x < item.other_x) ? item.coord_x : item.other_x;
    max_x = (item.coord_x > item.other_x) ? item.coord_x : item.other_x;
    min_z = (item.coord_z < item.other_z) ? item.coord_z : item.other_z;
    max_z = (item.coord_z > item.other_z) ? item.coord_z : item.other_z;
    rect_wdata.lo_x = cvc_pkg::sat32(36'(min_x) - cvc_pkg::ONE_Q16);
    rect_wdata.hi_x = cvc_pkg::sat32(36'(max_x) + cvc_pkg::ONE_Q16);
    rect_wdata.lo_z = cvc_pkg::sat32(36'(min_z) - cvc_pkg::ONE_Q16);
    rect_wdata.hi_z = cvc_pkg::sat32(36'(max_z) + cvc_pkg::ONE_Q16);
    circ_wdata.keep_in = item.hold_in;
    circ_wdata.cen_x   = item.coord_x;
    circ_wdata.cen_z   = item.coord_z;
    circ_wdata.rad     = cvc_pkg::sat32(item.hold_in
                           ? $signed({5'b0, item.radius}) - cvc_pkg::ONE_Q16
                           : $signed({5'b0, item.radius}) + cvc_pkg::ONE_Q16);
    rect_we = accept && (item.op == cvc_pkg::OP_RECT) && (32'(item.slot) < RECT_SLOTS);
    circ_we = accept && (item.op == cvc_pkg::OP_CIRCLE) &&
              (32'(item.slot) < CIRCLE_SLOTS);
  end

  cvc_ram #(
    .WIDTH ($bits(cvc_pkg::rect_t)),
    .DEPTH (RECT_SLOTS)
  ) u_rect_ram (
    .clk   (clk),
    .we    (rect_we),
    .waddr (RAW'(item.slot)),
    .wdata (rect_wdata),
    .raddr (idx[RAW-1:0]),
    .rdata (rect_rd)
  );

  cvc_ram #(
    .WIDTH ($bits(cvc_pkg::circ_t)),
    .DEPTH (CIRCLE_SLOTS)
  ) u_circ_ram (
    .clk   (clk),
    .we    (circ_we),
    .waddr (CAW'(item.slot)),
    .wdata (circ_wdata),
    .raddr (idx[CAW-1:0]),
    .rdata (circ_rd)
  );

  cvc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // helper terms of the table walk and the circle step
  always_comb begin
    idx_last = (IDX_W'(idx + 1'b1) == ((state == cvc_pkg::S_RECT_TEST) ? nr : nc));
    adx  = dx[31] ? 32'(-dx) : dx;
    adz  = dz[31] ? 32'(-dz) : dz;
    agap = gap[33] ? 33'(-gap) : 33'(gap);
    act  = keep ? ($signed({1'b0, radial}) > 33'(rad))
                : ($signed({1'b0, radial}) < 33'(rad));
    push = (state == cvc_pkg::S_DIVX_WAIT) ?
           ((dx[31] ^ gap[33]) ? -36'(alu_rsp.result[34:0]) : 36'(alu_rsp.result[34:0]))
         : ((dz[31] ^ gap[33]) ? -36'(alu_rsp.result[34:0]) : 36'(alu_rsp.result[34:0]));
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cvc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cvc_pkg::S_IDLE: begin
        if (accept && (item.op == cvc_pkg::OP_QUERY)) begin
          state_next = (nr != '0) ? cvc_pkg::S_RECT_RD : cvc_pkg::S_CIRC_PREP;
        end
      end
      cvc_pkg::S_RECT_RD:   state_next = cvc_pkg::S_RECT_TEST;
      cvc_pkg::S_RECT_TEST: state_next = idx_last ? cvc_pkg::S_CIRC_PREP
                                                  : cvc_pkg::S_RECT_RD;
      cvc_pkg::S_CIRC_PREP: state_next = (nc != '0) ? cvc_pkg::S_CIRC_RD
                                                    : cvc_pkg::S_FINISH;
      cvc_pkg::S_CIRC_RD:   state_next = cvc_pkg::S_CIRC_DIFF;
      cvc_pkg::S_CIRC_DIFF: state_next = cvc_pkg::S_SQX_GO;
      cvc_pkg::S_SQX_GO:    state_next = cvc_pkg::S_SQX_WAIT;
      cvc_pkg::S_SQX_WAIT:  if (alu_rsp.done) state_next = cvc_pkg::S_SQZ_GO;
      cvc_pkg::S_SQZ_GO:    state_next = cvc_pkg::S_SQZ_WAIT;
      cvc_pkg::S_SQZ_WAIT:  if (alu_rsp.done) state_next = cvc_pkg::S_ROOT_GO;
      cvc_pkg::S_ROOT_GO:   state_next = cvc_pkg::S_ROOT_WAIT;
      cvc_pkg::S_ROOT_WAIT: if (alu_rsp.done) state_next = cvc_pkg::S_DECIDE;
      cvc_pkg::S_DECIDE:    state_next = (act && (radial != '0)) ? cvc_pkg::S_MULX_GO
                                                                 : cvc_pkg::S_CIRC_NEXT;
      cvc_pkg::S_MULX_GO:   state_next = cvc_pkg::S_MULX_WAIT;
      cvc_pkg::S_MULX_WAIT: if (alu_rsp.done) state_next = cvc_pkg::S_DIVX_GO;
      cvc_pkg::S_DIVX_GO:   state_next = cvc_pkg::S_DIVX_WAIT;
      cvc_pkg::S_DIVX_WAIT: if (alu_rsp.done) state_next = cvc_pkg::S_MULZ_GO;
      cvc_pkg::S_MULZ_GO:   state_next = cvc_pkg::S_MULZ_WAIT;
      cvc_pkg::S_MULZ_WAIT: if (alu_rsp.done) state_next = cvc_pkg::S_DIVZ_GO;
      cvc_pkg::S_DIVZ_GO:   state_next = cvc_pkg::S_DIVZ_WAIT;
      cvc_pkg::S_DIVZ_WAIT: if (alu_rsp.done) state_next = cvc_pkg::S_CIRC_NEXT;
      cvc_pkg::S_CIRC_NEXT: state_next = idx_last ? cvc_pkg::S_FINISH
                                                  : cvc_pkg::S_CIRC_RD;
      cvc_pkg::S_FINISH:    state_next = cvc_pkg::S_IDLE;
      default:              state_next = cvc_pkg::S_IDLE;
    endcase
  end

  // outputs and shared unit requests
  always_comb begin
    busy        = (state != cvc_pkg::S_IDLE);
    done        = (state == cvc_pkg::S_FINISH);
    alu_req.go  = 1'b0;
    alu_req.op  = cvc_pkg::ALU_MUL;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state)
      cvc_pkg::S_SQX_GO: begin
        alu_req.go = 1'b1;
        alu_req.a  = 64'(adx);
        alu_req.b  = 64'(adx);
      end
      cvc_pkg::S_SQZ_GO: begin
        alu_req.go = 1'b1;
        alu_req.a  = 64'(adz);
        alu_req.b  = 64'(adz);
      end
      cvc_pkg::S_ROOT_GO: begin
        alu_req.go = 1'b1;
        alu_req.op = cvc_pkg::ALU_SQRT;
        alu_req.a  = acc;
      end
      cvc_pkg::S_MULX_GO: begin
        alu_req.go = 1'b1;
        alu_req.a  = 64'(adx);
        alu_req.b  = 64'(agap);
      end
      cvc_pkg::S_MULZ_GO: begin
        alu_req.go = 1'b1;
        alu_req.a  = 64'(adz);
        alu_req.b  = 64'(agap);
      end
      cvc_pkg::S_DIVX_GO, cvc_pkg::S_DIVZ_GO: begin
        alu_req.go = 1'b1;
        alu_req.op = cvc_pkg::ALU_DIV;
        alu_req.a  = acc;
        alu_req.b  = 64'(radial);
      end
      default: begin
        alu_req.go = 1'b0;
      end
    endcase
    result.clipped_x = nx;
    result.clipped_y = ny;
    result.clipped_z = nz;
    result.x_blocked = xb;
    result.z_blocked = zb;
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (state)
        cvc_pkg::S_IDLE: begin
          if (accept) begin
            cx  <= item.coord_x;
            cz  <= item.coord_z;
            ox  <= item.other_x;
            oz  <= item.other_z;
            vy  <= item.speed_y;
            mx  <= 33'(item.coord_x) + 33'(item.other_x);
            mz  <= 33'(item.coord_z) + 33'(item.other_z);
            xb  <= 1'b0;
            zb  <= 1'b0;
            idx <= '0;
          end
        end
        cvc_pkg::S_RECT_TEST: begin
          if (cvc_pkg::holds(rect_rd, mx, mz)) begin
            if (cvc_pkg::holds(rect_rd, mx, 33'(cz))) xb <= 1'b1;
            if (cvc_pkg::holds(rect_rd, 33'(cx), mz)) zb <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        cvc_pkg::S_CIRC_PREP: begin
          nx  <= xb ? '0 : ox;
          nz  <= zb ? '0 : oz;
          ny  <= (xb || zb) ? '0 : vy;
          mx  <= 33'(cx) + (xb ? 33'sd0 : 33'(ox));
          mz  <= 33'(cz) + (zb ? 33'sd0 : 33'(oz));
          idx <= '0;
        end
        cvc_pkg::S_CIRC_DIFF: begin
          dx   <= cvc_pkg::sat32(36'(circ_rd.cen_x) - 36'(mx));
          dz   <= cvc_pkg::sat32(36'(circ_rd.cen_z) - 36'(mz));
          rad  <= circ_rd.rad;
          keep <= circ_rd.keep_in;
        end
        cvc_pkg::S_SQX_WAIT: begin
          if (alu_rsp.done) acc <= alu_rsp.result;
        end
        cvc_pkg::S_SQZ_WAIT: begin
          if (alu_rsp.done) acc <= acc + alu_rsp.result;
        end
        cvc_pkg::S_ROOT_WAIT: begin
          if (alu_rsp.done) radial <= alu_rsp.result[31:0];
        end
        cvc_pkg::S_DECIDE: begin
          gap <= $signed({2'b00, radial}) - 34'(rad);
        end
        cvc_pkg::S_MULX_WAIT, cvc_pkg::S_MULZ_WAIT: begin
          if (alu_rsp.done) acc <= alu_rsp.result + 64'(radial[31:1]);
        end
        cvc_pkg::S_DIVX_WAIT: begin
          if (alu_rsp.done) nx <= cvc_pkg::sat32(36'(nx) + push);
        end
        cvc_pkg::S_DIVZ_WAIT: begin
          if (alu_rsp.done) nz <= cvc_pkg::sat32(36'(nz) + push);
        end
        cvc_pkg::S_CIRC_NEXT: begin
          idx <= idx + 1'b1;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

endmodule

/* sv/cvc_checker.sv */
// ----------------------------------------------------------------------------
// cvc_checker
// port-level checks of the collision velocity clipper
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cvc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input cvc_pkg::item_t item,
  input logic           done
);

  logic query_in, write_in;

  assign query_in = start && !busy && (item.op == cvc_pkg::OP_QUERY);
  assign write_in = start && !busy && (item.op != cvc_pkg::OP_QUERY);

  // a result only appears while a query is in flight
  `ASSERT_CLK(a_done_busy, clk, rst, done |-> busy)
  // a query word raises busy
  `ASSERT_CLK(a_query_busy, clk, rst, query_in |=> busy)
  // slot writes and unused ops finish at once
  `ASSERT_CLK(a_write_idle, clk, rst, write_in |=> !busy && !done)
  // the block frees up right after the result word
  `ASSERT_CLK(a_done_free, clk, rst, done |=> !busy && !done)

endmodule

bind collision_velocity_clip cvc_checker u_cvc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the collision velocity clipper. A predictor tracks the collider
// tables and counts, works out the clipped velocity of every query and
// compares each result word against it. The run goes through directed
// edge, push and extreme cases and then random table writes and queries,
// under several count settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS     = 16;
  localparam int QUIET_CYC = 64;
  localparam int WD_LIMIT  = 80000;
  localparam longint Q1    = 65536;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cvc_pkg::item_t item;
  logic cfg_we;
  logic [cvc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cvc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic done;
  cvc_pkg::result_t result;

  // predictor copy of the tables and counts
  longint tab_lo_x[SLOTS], tab_hi_x[SLOTS], tab_lo_z[SLOTS], tab_hi_z[SLOTS];
  longint ring_x[SLOTS], ring_z[SLOTS], ring_rad[SLOTS];
  bit ring_in[SLOTS];
  int rect_used, circ_used;

  cvc_pkg::result_t clip_queue[$];
  int errors;
  int quiet_cycles;
  bit never_idle;

  collision_velocity_clip dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit in_box(int i, longint x, longint z);
    return x >= tab_lo_x[i] && x <= tab_hi_x[i] && z >= tab_lo_z[i] && z <= tab_hi_z[i];
  endfunction

  // rounded share of the gap along one component, ties away from zero
  function automatic longint push_share(longint d, longint unsigned radial, longint gap);
    longint unsigned md, mg, q;
    md = (d < 0) ? -d : d;
    mg = (gap < 0) ? -gap : gap;
    q = (md * mg + radial / 2) / radial;
    return ((d < 0) != (gap < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // update the tables or work out the clipped velocity of one word
  function automatic void predict_clip(cvc_pkg::item_t it);
    longint cx, cz, ox, oz, mx, mz, nx, ny, nz, dx, dz, r, dd;
    longint unsigned radial;
    bit xb, zb, act;
    cvc_pkg::result_t res;
    cx = it.coord_x;
    cz = it.coord_z;
    ox = it.other_x;
    oz = it.other_z;
    case (it.op)
      cvc_pkg::OP_RECT: begin
        tab_lo_x[it.slot] = clamp32(((cx < ox) ? cx : ox) - Q1);
        tab_hi_x[it.slot] = clamp32(((cx > ox) ? cx : ox) + Q1);
        tab_lo_z[it.slot] = clamp32(((cz < oz) ? cz : oz) - Q1);
        tab_hi_z[it.slot] = clamp32(((cz > oz) ? cz : oz) + Q1);
      end
      cvc_pkg::OP_CIRCLE: begin
        ring_x[it.slot] = cx;
        ring_z[it.slot] = cz;
        ring_rad[it.slot] = clamp32(it.hold_in ? longint'(it.radius) - Q1
                                               : longint'(it.radius) + Q1);
        ring_in[it.slot] = it.hold_in;
      end
      cvc_pkg::OP_QUERY: begin
        mx = cx + ox;
        mz = cz + oz;
        xb = 0;
        zb = 0;
        for (int i = 0; i < rect_used; i++) begin
          if (in_box(i, mx, mz)) begin
            if (in_box(i, mx, cz)) xb = 1;
            if (in_box(i, cx, mz)) zb = 1;
          end
        end
        nx = xb ? 0 : ox;
        nz = zb ? 0 : oz;
        ny = (xb || zb) ? 0 : longint'(it.speed_y);
        mx = cx + nx;
        mz = cz + nz;
        for (int i = 0; i < circ_used; i++) begin
          dx = clamp32(ring_x[i] - mx);
          dz = clamp32(ring_z[i] - mz);
          radial = root_floor(longint'(dx * dx) + longint'(dz * dz));
          r = ring_rad[i];
          dd = radial;
          act = ring_in[i] ? (dd > r) : (dd < r);
          if (act && radial != 0) begin
            nx = clamp32(nx + push_share(dx, radial, dd - r));
            nz = clamp32(nz + push_share(dz, radial, dd - r));
          end
        end
        res.clipped_x = nx[31:0];
        res.clipped_y = ny[31:0];
        res.clipped_z = nz[31:0];
        res.x_blocked = xb;
        res.z_blocked = zb;
        clip_queue = {clip_queue, res};
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    cvc_pkg::result_t want;
    if (!rst && done) begin
      if (clip_queue.size() == 0) begin
        report_mismatch("result with no query pending");
      end else begin
        want = clip_queue.pop_front();
        if (result.clipped_x !== want.clipped_x)
          report_mismatch($sformatf("clipped_x %h want %h", result.clipped_x, want.clipped_x));
        if (result.clipped_y !== want.clipped_y)
          report_mismatch($sformatf("clipped_y %h want %h", result.clipped_y, want.clipped_y));
        if (result.clipped_z !== want.clipped_z)
          report_mismatch($sformatf("clipped_z %h want %h", result.clipped_z, want.clipped_z));
        if (result.x_blocked !== want.x_blocked)
          report_mismatch($sformatf("x_blocked %b want %b", result.x_blocked, want.x_blocked));
        if (result.z_blocked !== want.z_blocked)
          report_mismatch($sformatf("z_blocked %b want %b", result.z_blocked, want.z_blocked));
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("timeout waiting for the clipper");
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one word; start stays high until the caller idles or drains
  task automatic send_word(cvc_pkg::item_t it);
    if (!never_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_clip(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (QUIET_CYC) @(posedge clk);
  endtask

  task automatic set_counts(int rects, int circs);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= cvc_pkg::CFG_RECT_COUNT;
    cfg_data <= rects[cvc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= cvc_pkg::CFG_CIRCLE_COUNT;
    cfg_data <= circs[cvc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    rect_used = (rects > SLOTS) ? SLOTS : rects;
    circ_used = (circs > SLOTS) ? SLOTS : circs;
  endtask

  function automatic cvc_pkg::item_t make_word(logic [1:0] op, int slot, longint a_x,
                                               longint a_z, longint b_x, longint b_z,
                                               longint vy, longint rad, bit keep_flag);
    cvc_pkg::item_t it;
    it.op = op;
    it.slot = slot[3:0];
    it.coord_x = a_x[31:0];
    it.coord_z = a_z[31:0];
    it.other_x = b_x[31:0];
    it.other_z = b_z[31:0];
    it.speed_y = vy[31:0];
    it.radius = rad[30:0];
    it.hold_in = keep_flag;
    return it;
  endfunction

  function automatic longint near_val(int span);
    return longint'($urandom_range(0, 32'(2 * span * Q1))) - span * Q1;
  endfunction

  function automatic cvc_pkg::item_t random_word();
    cvc_pkg::item_t it;
    int pick;
    logic [223:0] noise;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // noise over the whole field range
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(cvc_pkg::item_t)-1:0];
      if (pick < 12 && it.op == cvc_pkg::OP_UNUSED) it.op = cvc_pkg::OP_QUERY;
    end else if (pick < 40) begin
      it = make_word(cvc_pkg::OP_RECT, $urandom_range(15), near_val(40), near_val(40),
                     near_val(40), near_val(40), 0, 0, 0);
    end else if (pick < 55) begin
      it = make_word(cvc_pkg::OP_CIRCLE, $urandom_range(15), near_val(40), near_val(40),
                     0, 0, 0, $urandom_range(0, 32'(50 * Q1)), 1'($urandom_range(1)));
    end else begin
      it = make_word(cvc_pkg::OP_QUERY, 0, near_val(40), near_val(40), near_val(6),
                     near_val(6), longint'($urandom) - 64'sd2147483648, 0, 0);
    end
    return it;
  endfunction

  // fill every slot so no query reads an unwritten entry
  task automatic test_table_fill();
    for (int s = 0; s < SLOTS; s++) begin
      send_word(make_word(cvc_pkg::OP_RECT, s, 100 * Q1 + s * Q1, 100 * Q1,
                          102 * Q1 + s * Q1, 103 * Q1, 0, 0, 0));
      send_word(make_word(cvc_pkg::OP_CIRCLE, s, -200 * Q1, -200 * Q1, 0, 0, 0, Q1, 0));
    end
  endtask

  // inclusive rectangle edges, each blocking combination
  task automatic test_rect_edges();
    send_word(make_word(cvc_pkg::OP_RECT, 0, 10 * Q1, 10 * Q1, 0, 0, 0, 0, 0));
    set_counts(1, 0);
    send_word(make_word(cvc_pkg::OP_QUERY, 0, -5 * Q1, 5 * Q1, 4 * Q1, 0, 7 * Q1, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, -5 * Q1, 5 * Q1, 4 * Q1 - 1, 0, 7 * Q1,
                        0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 5 * Q1, 13 * Q1, 0, -2 * Q1, -3, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 13 * Q1, 13 * Q1, -2 * Q1, -2 * Q1, 9,
                        0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 5 * Q1, 5 * Q1, Q1, Q1, 9, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 30 * Q1, 5 * Q1, Q1, 0, 9, 0, 0));
  endtask

  // keep-in and keep-out pushes, and a circle at zero distance
  task automatic test_circle_push();
    send_word(make_word(cvc_pkg::OP_CIRCLE, 0, 20 * Q1, 20 * Q1, 0, 0, 0, 5 * Q1, 0));
    send_word(make_word(cvc_pkg::OP_CIRCLE, 1, 0, 0, 0, 0, 0, 10 * Q1, 1));
    set_counts(0, 2);
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 20 * Q1, 20 * Q1, 0, 0, 3, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 17 * Q1, 21 * Q1, Q1, 0, 3, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 8 * Q1, 0, 3 * Q1, -Q1, 3, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, 0, 0, 0, 0, 3, 0, 0));
  endtask

  // field extremes and saturation of bounds, radii and pushes
  task automatic test_extremes();
    longint maxv, minv;
    maxv = 64'sd2147483647;
    minv = -64'sd2147483648;
    send_word(make_word(cvc_pkg::OP_RECT, 2, maxv, maxv, minv, minv, 0, 0, 0));
    send_word(make_word(cvc_pkg::OP_CIRCLE, 2, maxv, minv, 0, 0, 0, 64'h7fffffff, 0));
    send_word(make_word(cvc_pkg::OP_CIRCLE, 3, minv, maxv, 0, 0, 0, 0, 1));
    send_word(make_word(cvc_pkg::OP_UNUSED, 5, maxv, maxv, maxv, maxv, maxv,
                        64'h7fffffff, 1));
    set_counts(31, 31);
    send_word(make_word(cvc_pkg::OP_QUERY, 0, maxv, maxv, maxv, maxv, maxv, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, minv, minv, minv, minv, minv, 0, 0));
    send_word(make_word(cvc_pkg::OP_QUERY, 0, minv, maxv, 0, 0, maxv, 0, 0));
  endtask

  // random words under several count settings, one stretch never idle
  task automatic test_random_mix();
    int rc[6] = '{0, 3, 16, 31, 1, 5};
    int cc[6] = '{0, 2, 16, 4, 31, 1};
    for (int p = 0; p < 6; p++) begin
      set_counts(rc[p], cc[p]);
      never_idle = (p == 2);
      for (int n = 0; n < 125; n++) send_word(random_word());
    end
    never_idle = 0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    never_idle = 0;
    rect_used = 0;
    circ_used = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_fill();
    test_rect_edges();
    test_circle_push();
    test_extremes();
    test_random_mix();
    drain();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
